### rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and codes for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

  localparam int KEY_BITS      = 32;
  localparam int TAG_PORT_BITS = 16;
  localparam int LIMIT_BITS    = 7;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic                       operation;
    logic signed [KEY_BITS-1:0] priority_req;
    logic [TAG_PORT_BITS-1:0]   payload;
  } bmh_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [TAG_PORT_BITS-1:0] removed_payload;
  } bmh_result_t;

endpackage

`default_nettype wire

### rtl/binary_min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// Min-heap priority queue with signed keys and payload tags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one operation per transaction: insert (key, payload)
//   or remove-minimum. m_* channel returns exactly one result per operation:
//   a status code and, for a successful remove, the payload of the minimum.
//   cfg_* writes max_entries, the usable slot count; write it only while the
//   queue is idle. Values above CAPACITY act as CAPACITY.
// Timing:
//   One operation is in flight at a time; the heap lives in a single memory
//   with a registered read port.
//   Insert: each level climbed moves the parent down while the next parent
//   is read; an entry that climbs to the root is then dropped there.
//   Remove: fetch the root, then the last entry; then, per level descended,
//   read the left child, then read the right child (if any) and compare.
//   s_tready rises with m_tvalid.
// Reset: the heap is empty and max_entries is 64; slot contents are unknown
//   but are never read before being written.
// Stall: the result waits in an output register; the next operation is
//   accepted meanwhile, and its result is held in the core until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_priority_queue #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  // operation stream
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [47:0] s_tdata,   // [31:0] priority_req, [47:32] payload
  input  wire [0:0]  s_tuser,   // [0] operation
  // result stream
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // [15:0] removed_payload
  output logic [1:0]  m_tuser,  // [1:0] status
  // configuration: max_entries
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [6:0]  cfg_data
);
  import bmh_pkg::*;

  logic [LIMIT_BITS-1:0] max_entries;
  bmh_cmd_t              cmd;
  bmh_result_t           core_res;
  bmh_result_t           out_res;
  logic                  core_idle;
  logic                  core_res_valid;
  logic                  out_free;
  logic                  accept;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= LIMIT_RESET;
    end else if (cfg_valid) begin
      max_entries <= cfg_data;
    end
  end

  // unpack the operation transaction
  assign cmd.operation    = s_tuser[0];
  assign cmd.priority_req = $signed(s_tdata[KEY_BITS-1:0]);
  assign cmd.payload      = s_tdata[KEY_BITS +: TAG_PORT_BITS];

  assign s_tready = core_idle;
  assign accept   = s_tvalid && s_tready;

  // output register frees when empty or drained this cycle
  assign out_free = !m_tvalid || m_tready;

  bmh_core #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .cmd         (cmd),
    .max_entries (max_entries),
    .idle        (core_idle),
    .res_valid   (core_res_valid),
    .res_ready   (out_free),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (core_res_valid && out_free) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = out_res.removed_payload;
  assign m_tuser = out_res.status;

  // one operation in flight: an accept closes the input next cycle
  a_single_op: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while an operation is in flight");

  // a finished result is held in the core until the output register takes it
  a_res_held: assert property (@(posedge clk) disable iff (rst)
    core_res_valid && !out_free |=> core_res_valid && $stable(core_res))
    else $error("core result dropped or changed while output stalled");

  // a failed operation (full or empty) returns a zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    core_res_valid && core_res.status != STAT_DONE |-> core_res.removed_payload == '0)
    else $error("payload returned with a failure status");

  // no input accepted while the core still holds an undelivered result
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    core_res_valid |-> !s_tready)
    else $error("input ready while result pending in core");

endmodule

`default_nettype wire

### rtl/bmh_core.sv
// ----------------------------------------------------------------------------
// bmh_core
// Heap storage and sift sequencer: one entry memory, one operation at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_core #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  bmh_pkg::bmh_cmd_t             cmd,
  input  wire [bmh_pkg::LIMIT_BITS-1:0] max_entries,
  output logic                          idle,
  output logic                          res_valid,
  input  wire                           res_ready,
  output bmh_pkg::bmh_result_t          res
);
  import bmh_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = CW + 1;
  localparam int MW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_REM_ROOT = 3'd2;
  localparam logic [2:0] S_REM_LAST = 3'd3;
  localparam logic [2:0] S_SD_L     = 3'd4;
  localparam logic [2:0] S_SD_R     = 3'd5;
  localparam logic [2:0] S_PUT      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // entry layout: {key, tag}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [IW-1:0]           idx, idx_next;
  logic [IW-1:0]           cidx, cidx_next;
  logic [EW-1:0]           mov, mov_next;
  logic [EW-1:0]           cand, cand_next;
  logic [1:0]              status, status_next;
  logic [PAYLOAD_BITS-1:0] rem_tag, rem_tag_next;

  logic [63:0]             pl_wide, rem_wide;
  logic [PAYLOAD_BITS-1:0] tag_in;
  logic [EW-1:0]           new_entry;
  logic                    full;
  logic [MW-1:0]           count_m;
  logic [IW-1:0]           pidx;
  logic [LW-1:0]           ridx, lnext;
  logic [EW-1:0]           chosen;
  logic [IW-1:0]           chosen_idx;
  logic                    do_step;

  function automatic logic signed [KEY_BITS-1:0] key_of(input logic [EW-1:0] e);
    return $signed(e[EW-1 -: KEY_BITS]);
  endfunction

  assign pl_wide   = 64'(cmd.payload);
  assign tag_in    = pl_wide[PAYLOAD_BITS-1:0];
  assign new_entry = {cmd.priority_req, tag_in};

  // limit above capacity acts as capacity
  assign count_m = MW'(count);
  assign full    = (count_m >= MW'(max_entries)) || (count_m >= MW'(CAPACITY));

  assign pidx = (idx - IW'(1)) >> 1;
  assign ridx = LW'(cidx) + LW'(1);

  always_comb begin
    if (state == S_SD_R && key_of(rd_data) < key_of(cand)) begin
      chosen     = rd_data;
      chosen_idx = ridx[IW-1:0];
    end else if (state == S_SD_R) begin
      chosen     = cand;
      chosen_idx = cidx;
    end else begin
      chosen     = rd_data;
      chosen_idx = cidx;
    end
  end

  assign lnext = (LW'(chosen_idx) << 1) + LW'(1);

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    cidx_next    = cidx;
    mov_next     = mov;
    cand_next    = cand;
    status_next  = status;
    rem_tag_next = rem_tag;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx;
    wr_data      = mov;
    do_step      = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          rem_tag_next = '0;
          status_next  = STAT_DONE;
          if (cmd.operation == OP_INSERT) begin
            mov_next = new_entry;
            if (full) begin
              status_next = STAT_FULL;
              state_next  = S_DONE;
            end else begin
              count_next = count + CW'(1);
              idx_next   = count[IW-1:0];
              if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_entry;
                state_next = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = (count[IW-1:0] - IW'(1)) >> 1;
                state_next = S_INS_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = STAT_EMPTY;
              state_next  = S_DONE;
            end else begin
              count_next = count - CW'(1);
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = S_REM_ROOT;
            end
          end
        end
      end

      // rd_data holds the parent of idx
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (key_of(mov) < key_of(rd_data)) begin
          wr_data  = rd_data;
          idx_next = pidx;
          if (pidx == '0) begin
            state_next = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = (pidx - IW'(1)) >> 1;
          end
        end else begin
          state_next = S_DONE;
        end
      end

      S_REM_ROOT: begin
        rem_tag_next = rd_data[PAYLOAD_BITS-1:0];
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = count[IW-1:0];
          state_next = S_REM_LAST;
        end
      end

      // last entry becomes the moving entry, hole at the root
      S_REM_LAST: begin
        mov_next = rd_data;
        idx_next = '0;
        if (count == CW'(1)) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = rd_data;
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IW'(1);
          cidx_next  = IW'(1);
          state_next = S_SD_L;
        end
      end

      S_SD_L: begin
        cand_next = rd_data;
        if (ridx < LW'(count)) begin
          rd_en      = 1'b1;
          rd_addr    = ridx[IW-1:0];
          state_next = S_SD_R;
        end else begin
          do_step = 1'b1;
        end
      end

      S_SD_R: begin
        do_step = 1'b1;
      end

      S_PUT: begin
        wr_en      = 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_step) begin
      wr_en = 1'b1;
      if (key_of(chosen) < key_of(mov)) begin
        wr_data  = chosen;
        idx_next = chosen_idx;
        if (lnext < LW'(count)) begin
          rd_en      = 1'b1;
          rd_addr    = lnext[IW-1:0];
          cidx_next  = lnext[IW-1:0];
          state_next = S_SD_L;
        end else begin
          state_next = S_PUT;
        end
      end else begin
        state_next = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx     <= idx_next;
    cidx    <= cidx_next;
    mov     <= mov_next;
    cand    <= cand_next;
    status  <= status_next;
    rem_tag <= rem_tag_next;
  end

  assign rem_wide            = 64'(rem_tag);
  assign idle                = (state == S_IDLE);
  assign res_valid           = (state == S_DONE);
  assign res.status          = status;
  assign res.removed_payload = rem_wide[TAG_PORT_BITS-1:0];

endmodule

`default_nettype wire
